// ----- src/lagrange_interpolation_eval_unit_assert.svh -----
// Assertion helpers for the RTL files, included by lagr_ctrl.
`ifndef LAGRANGE_INTERPOLATION_EVAL_UNIT_ASSERT_SVH
`define LAGRANGE_INTERPOLATION_EVAL_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define LAGR_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define LAGR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lagr_pkg.sv -----
// ----------------------------------------------------------------------------
// lagr_pkg
// Shared types and constants of the Lagrange interpolation evaluator.
// ----------------------------------------------------------------------------
package lagr_pkg;

  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 5;
  localparam int NCFG_W  = 6;

  // Result status codes
  localparam logic [STAT_W-1:0] STATUS_OK  = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_SAT = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_DUP = 2'd2;

  // Input item kind
  typedef enum logic {
    KIND_LOAD = 1'b0,
    KIND_EVAL = 1'b1
  } kind_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic wr_en;       // write node into tables
    logic eval_start;  // latch t, clear accumulator and flags
    logic lat_i;       // latch x_i, y_i, basis factor to 1.0
    logic lat_nd;      // latch numerator and denominator
    logic mul_s;       // product basis * numerator
    logic div_start;   // launch divider
    logic s_upd;       // take saturated quotient as basis factor
    logic mul_y;       // product basis * y_i
    logic acc_add;     // add rounded term
    logic dup_set;     // mark duplicate abscissa
    logic out_load;    // load output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic den_zero;
    logic div_done;
  } sts_t;

endpackage

// ----- src/lagr_ram.sv -----
// ----------------------------------------------------------------------------
// lagr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lagr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lagr_div.sv -----
// ----------------------------------------------------------------------------
// lagr_div
// Restoring unsigned divider, 64-bit dividend by 33-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module lagr_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dvd,
  input  logic [32:0] dvs,
  output logic [63:0] quo,
  output logic        done
);

  logic [32:0] rem;
  logic [32:0] d;
  logic [6:0]  cnt;
  logic        busy;
  logic [33:0] rem_sh;
  logic [33:0] diff;
  logic        ge;

  // one trial subtraction
  always_comb begin
    rem_sh = {rem, quo[63]};
    ge     = rem_sh >= {1'b0, d};
    diff   = rem_sh - {1'b0, d};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 7'd64;
      end else if (busy) begin
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dvd;
      d   <= dvs;
    end else if (busy) begin
      rem <= ge ? diff[32:0] : rem_sh[32:0];
      quo <= {quo[62:0], ge};
    end
  end

endmodule

// ----- src/lagr_dp.sv -----
// ----------------------------------------------------------------------------
// lagr_dp
// Datapath: node tables, basis multiply/divide, term rounding, accumulator
// and result register.
// ----------------------------------------------------------------------------
module lagr_dp
  import lagr_pkg::*;
#(
  parameter int MAX_NODES = 32,
  parameter int FRAC_BITS = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  output sts_t                         sts,
  input  logic [IDX_W-1:0]             node_index,
  input  logic signed [VAL_W-1:0]      node_x,
  input  logic signed [VAL_W-1:0]      node_y,
  input  logic signed [VAL_W-1:0]      point_t,
  input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
  output logic signed [VAL_W-1:0]      value,
  output logic [STAT_W-1:0]            status
);

  localparam int AW = $clog2(MAX_NODES);
  localparam logic signed [31:0] ONE   = 32'sd1 <<< FRAC_BITS;
  localparam logic signed [64:0] HALF  = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] S32MX = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] S32MN = -64'sh0000_0000_8000_0000;

  logic [31:0]        x_rd;
  logic [31:0]        y_rd;
  logic signed [31:0] t_r;
  logic signed [31:0] xi;
  logic signed [31:0] yi;
  logic signed [32:0] num;
  logic signed [32:0] den;
  logic signed [31:0] s;
  logic signed [64:0] prod;
  logic signed [63:0] prody;
  logic signed [63:0] acc;
  logic               sat_flag;
  logic               dup_flag;
  logic               quo_neg;
  logic [64:0]        prod_mag;
  logic [32:0]        den_mag;
  logic [63:0]        quo;
  logic               div_done;
  logic signed [31:0] s_new;
  logic               s_sat;
  logic [32:0]        q_neg;
  logic signed [64:0] tsum;
  logic signed [64:0] tsh;

  // node tables
  lagr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_xram (
    .clk(clk), .we(cmd.wr_en), .waddr(AW'(node_index)), .wdata(node_x),
    .raddr(rd_addr), .rdata(x_rd)
  );

  lagr_ram #(.WIDTH(VAL_W), .DEPTH(MAX_NODES)) u_yram (
    .clk(clk), .we(cmd.wr_en), .waddr(AW'(node_index)), .wdata(node_y),
    .raddr(rd_addr), .rdata(y_rd)
  );

  // magnitudes for the divider
  always_comb begin
    prod_mag = prod[64] ? 65'(-prod) : 65'(prod);
    den_mag  = den[32] ? 33'(-den) : 33'(den);
  end

  lagr_div u_div (
    .clk(clk), .rst(rst), .start(cmd.div_start),
    .dvd(prod_mag[63:0]), .dvs(den_mag), .quo(quo), .done(div_done)
  );

  // signed, saturated quotient
  always_comb begin
    q_neg = 33'd0 - {1'b0, quo[31:0]};
    s_sat = 1'b0;
    if (quo_neg) begin
      if (quo > 64'h8000_0000) begin
        s_new = 32'sh8000_0000;
        s_sat = 1'b1;
      end else begin
        s_new = q_neg[31:0];
      end
    end else begin
      if (quo > 64'h7FFF_FFFF) begin
        s_new = 32'sh7FFF_FFFF;
        s_sat = 1'b1;
      end else begin
        s_new = quo[31:0];
      end
    end
  end

  // round term to FRAC_BITS fraction bits
  always_comb begin
    tsum = {prody[63], prody} + HALF;
    tsh  = tsum >>> FRAC_BITS;
  end

  assign sts.den_zero = (den == 33'sd0);
  assign sts.div_done = div_done;

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      sat_flag <= 1'b0;
      dup_flag <= 1'b0;
    end else if (cmd.eval_start) begin
      sat_flag <= 1'b0;
      dup_flag <= 1'b0;
    end else begin
      if (cmd.s_upd && s_sat) begin
        sat_flag <= 1'b1;
      end
      if (cmd.dup_set) begin
        dup_flag <= 1'b1;
      end
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      t_r <= point_t;
      acc <= '0;
    end
    if (cmd.lat_i) begin
      xi <= x_rd;
      yi <= y_rd;
      s  <= ONE;
    end
    if (cmd.lat_nd) begin
      num <= {t_r[31], t_r} - {x_rd[31], x_rd};
      den <= {xi[31], xi} - {x_rd[31], x_rd};
    end
    if (cmd.mul_s) begin
      prod <= s * num;
    end
    if (cmd.div_start) begin
      quo_neg <= prod[64] ^ den[32];
    end
    if (cmd.s_upd) begin
      s <= s_new;
    end
    if (cmd.mul_y) begin
      prody <= s * yi;
    end
    if (cmd.acc_add) begin
      acc <= acc + tsh[63:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (dup_flag || cmd.dup_set) begin
        value  <= '0;
        status <= STATUS_DUP;
      end else if (acc > S32MX) begin
        value  <= 32'sh7FFF_FFFF;
        status <= STATUS_SAT;
      end else if (acc < S32MN) begin
        value  <= 32'sh8000_0000;
        status <= STATUS_SAT;
      end else begin
        value  <= acc[31:0];
        status <= sat_flag ? STATUS_SAT : STATUS_OK;
      end
    end
  end

endmodule

// ----- src/lagr_ctrl.sv -----
`include "lagrange_interpolation_eval_unit_assert.svh"
// ----------------------------------------------------------------------------
// lagr_ctrl
// Controller: handshakes, node count register, loop counters over i and j,
// and command decode for the datapath.
// ----------------------------------------------------------------------------
module lagr_ctrl
  import lagr_pkg::*;
#(
  parameter int MAX_NODES = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_valid,
  output logic                         s_ready,
  input  logic                         kind,
  input  logic [IDX_W-1:0]             node_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [NCFG_W-1:0]            cfg_data,
  output logic                         m_valid,
  input  logic                         m_ready,
  output cmd_t                         cmd,
  input  sts_t                         sts,
  output logic [$clog2(MAX_NODES)-1:0] rd_addr
);

  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_I,
    ST_LAT_I,
    ST_J_CHK,
    ST_J_LAT,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_TERM,
    ST_ACC,
    ST_FINISH
  } state_t;

  state_t            state;
  logic [NCFG_W-1:0] node_count;
  logic [CW-1:0]     n_cnt;
  logic [CW-1:0]     i;
  logic [CW-1:0]     j;
  logic [CW-1:0]     n_sel;
  logic              accept;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign s_ready   = (state == ST_IDLE);
  assign accept    = s_valid && s_ready;
  assign out_free  = !m_valid || m_ready;
  assign n_sel     = (32'(node_count) > MAX_NODES) ? CW'(MAX_NODES) : CW'(node_count);
  assign rd_addr   = (state == ST_RD_I) ? i[AW-1:0] : j[AW-1:0];

  // command decode
  always_comb begin
    cmd            = '0;
    cmd.wr_en      = accept && (kind == KIND_LOAD) && (32'(node_index) < MAX_NODES);
    cmd.eval_start = accept && (kind == KIND_EVAL);
    unique case (state)
      ST_LAT_I:    cmd.lat_i     = 1'b1;
      ST_J_LAT:    cmd.lat_nd    = 1'b1;
      ST_MUL: begin
        cmd.dup_set = sts.den_zero;
        cmd.mul_s   = !sts.den_zero;
      end
      ST_DIV_GO:   cmd.div_start = 1'b1;
      ST_DIV_WAIT: cmd.s_upd     = sts.div_done;
      ST_TERM:     cmd.mul_y     = 1'b1;
      ST_ACC:      cmd.acc_add   = 1'b1;
      ST_FINISH:   cmd.out_load  = out_free;
      default: ;
    endcase
  end

  // state, counters and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      node_count <= '0;
      n_cnt      <= '0;
      i          <= '0;
      j          <= '0;
      m_valid    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        node_count <= cfg_data;
      end
      if (m_valid && m_ready) begin
        m_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept && kind == KIND_EVAL) begin
            n_cnt <= n_sel;
            i     <= '0;
            state <= (n_sel == '0) ? ST_FINISH : ST_RD_I;
          end
        end
        ST_RD_I:  state <= ST_LAT_I;
        ST_LAT_I: begin
          j     <= '0;
          state <= ST_J_CHK;
        end
        ST_J_CHK: begin
          if (j == n_cnt) begin
            state <= ST_TERM;
          end else if (j == i) begin
            j <= j + CW'(1);
          end else begin
            state <= ST_J_LAT;
          end
        end
        ST_J_LAT: state <= ST_MUL;
        ST_MUL:   state <= sts.den_zero ? ST_FINISH : ST_DIV_GO;
        ST_DIV_GO: state <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (sts.div_done) begin
            j     <= j + CW'(1);
            state <= ST_J_CHK;
          end
        end
        ST_TERM: state <= ST_ACC;
        ST_ACC: begin
          i     <= i + CW'(1);
          state <= (i + CW'(1) == n_cnt) ? ST_FINISH : ST_RD_I;
        end
        ST_FINISH: begin
          if (out_free) begin
            m_valid <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `LAGR_ASSERT_IMPL(a_node_read_in_range, clk, rst, state == ST_RD_I, i < n_cnt,
    "outer node index out of range")
  `LAGR_ASSERT_IMPL(a_inner_in_range, clk, rst, state == ST_J_CHK, j <= n_cnt,
    "inner node index past node count")
  `LAGR_ASSERT_NEXT(a_div_wait_exit, clk, rst, state == ST_DIV_WAIT,
    state == ST_DIV_WAIT || state == ST_J_CHK, "left divide wait wrongly")
  `LAGR_ASSERT_NEXT(a_finish_holds, clk, rst, state == ST_FINISH && m_valid && !m_ready,
    state == ST_FINISH && m_valid, "result overwritten while pending")

endmodule

// ----- src/lagrange_interpolation_eval_unit.sv -----
// Load items are written at the accepting edge and leave the input open. An evaluation over
// n nodes raises its result after n outer steps of n-1 basis steps each, or at the first
// duplicate abscissa; each basis step runs the 64-step bit-serial divider shared across steps.
// One item is in work at a time; the input reopens in the same cycle as the result is raised.
// A pending result does not block the input; a finishing evaluation waits for it.
// Synchronous active-high reset clears node_count and control; node tables stay undefined.
// ----------------------------------------------------------------------------
// lagrange_interpolation_eval_unit
// Lagrange polynomial evaluator over a table of fixed-point nodes.
// ----------------------------------------------------------------------------
module lagrange_interpolation_eval_unit
  import lagr_pkg::*;
#(
  parameter int MAX_NODES = 32,
  parameter int FRAC_BITS = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // node_index[4:0], node_x[36:5], node_y[68:37], point_t[100:69], zero pad
  input  logic [103:0]        s_axis_tdata,
  // kind[0]
  input  logic                s_axis_tuser,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [NCFG_W-1:0]   cfg_data,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // value[31:0]
  output logic [31:0]         m_axis_tdata,
  // status[1:0]
  output logic [STAT_W-1:0]   m_axis_tuser
);

  localparam int AW = $clog2(MAX_NODES);

  cmd_t                  cmd;
  sts_t                  sts;
  logic [AW-1:0]         rd_addr;
  logic signed [31:0]    value;

  lagr_ctrl #(.MAX_NODES(MAX_NODES)) u_ctrl (
    .clk(clk), .rst(rst),
    .s_valid(s_axis_tvalid), .s_ready(s_axis_tready),
    .kind(s_axis_tuser), .node_index(s_axis_tdata[4:0]),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .m_valid(m_axis_tvalid), .m_ready(m_axis_tready),
    .cmd(cmd), .sts(sts), .rd_addr(rd_addr)
  );

  lagr_dp #(.MAX_NODES(MAX_NODES), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .node_index(s_axis_tdata[4:0]),
    .node_x(s_axis_tdata[36:5]),
    .node_y(s_axis_tdata[68:37]),
    .point_t(s_axis_tdata[100:69]),
    .rd_addr(rd_addr),
    .value(value), .status(m_axis_tuser)
  );

  assign m_axis_tdata = value;

endmodule
